// ----- rtl/ecg_beat_rate_and_trace_macros.svh -----
// ----------------------------------------------------------------------------
// ECG beat rate and trace assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ECG_BEAT_RATE_AND_TRACE_MACROS_SVH
`define ECG_BEAT_RATE_AND_TRACE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define ECGBR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define ECGBR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ECGBR_ASSERT_IMP(lbl, ante, cons)
`define ECGBR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ecgbr_pkg.sv -----
// ----------------------------------------------------------------------------
// ECG beat rate package
// Sizes, register indexes and divider interface types for the block.
// ----------------------------------------------------------------------------
package ecgbr_pkg;

	localparam int PLOT_WIDTH  = 128;
	localparam int WAVE_ROWS   = 48;
	localparam int SAMPLE_BITS = 10;

	localparam int X_W        = $clog2(PLOT_WIDTH);
	localparam int ROW_W      = $clog2(WAVE_ROWS);
	localparam int SPAN       = WAVE_ROWS - 1;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	localparam int ROW_RESET  = WAVE_ROWS / 2;

	localparam int TIME_W     = 32;
	localparam int THR_W      = SAMPLE_BITS;
	localparam int REFR_W     = 16;
	localparam int RATE_W     = 8;
	localparam int CFG_DATA_W = (THR_W > REFR_W) ? THR_W : REFR_W;
	localparam int CFG_IDX_W  = 1;

	localparam int THR_RESET  = 550;
	localparam int REFR_RESET = 300;

	localparam int MS_PER_MIN = 60000;
	localparam int RATE_MAX   = 255;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BEAT_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_MS  = 1'd1;

	// row scaling product, then divider sized for the ms-per-minute dividend
	localparam int PROD_W    = SAMPLE_BITS + ROW_W;
	localparam int DIV_NW    = $clog2(MS_PER_MIN + 1);
	localparam int DIV_DW    = TIME_W;
	localparam int DIV_CNT_W = $clog2(DIV_NW);

	// stream word sizes
	localparam int IN_BITS     = SAMPLE_BITS + TIME_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = X_W + 2 * ROW_W + 1 + 1 + RATE_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ----- rtl/ecgbr_div.sv -----
// ----------------------------------------------------------------------------
// ECG beat rate shared divider
// Restoring bit-serial divider, one quotient bit per cycle, done pulse after.
// ----------------------------------------------------------------------------
module ecgbr_div import ecgbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output div_sts_t          sts,
	output logic [DIV_NW-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    num_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    den_q;

	logic [DIV_DW:0] trial;
	logic [DIV_DW:0] diff;
	logic            qbit;

	// shift in the next dividend bit and try one subtract
	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			num_q <= {num_q[DIV_NW-2:0], qbit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = num_q;

endmodule

// ----- rtl/ecg_beat_rate_and_trace.sv -----
// ----------------------------------------------------------------------------
// ECG beat rate and trace
// Scales each ECG sample to a plot row, emits a trace segment, detects
// R peaks and measures heart rate with one shared bit-serial divider.
// ----------------------------------------------------------------------------
// channel   direction  handshake           contents
// s_*       in         s_tvalid/s_tready   sample, time_ms
// m_*       out        m_tvalid/m_tready   segment, clear, beat, rate
// cfg_*     in         cfg_we              beat_threshold, refractory_ms
//
// After a sample is accepted, the ROW state scales the row with a reciprocal
// shift-add and the FIN state loads the result word. A beat that yields a
// new rate first runs the 16-step divider (start, steps, done) between the
// two. The input is ready again as the result loads, so the next sample can
// be taken while the result is presented. Reset is asynchronous, active
// low; sequencer state and configuration return to defaults, data is not reset.
// A result waiting on m_tready holds the sequencer only at its last step; the
// next sample may be accepted while the previous result still waits.
// ----------------------------------------------------------------------------
`include "ecg_beat_rate_and_trace_macros.svh"

module ecg_beat_rate_and_trace import ecgbr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample [SAMPLE_BITS-1:0], time_ms [next 32 bits], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// seg_x, seg_row_from, seg_row_to, clear_wave, beat, heart_rate,
	// rate_known, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ROW       = 3'd1;
	localparam logic [2:0] ST_RATE_GO   = 3'd2;
	localparam logic [2:0] ST_RATE_WAIT = 3'd3;
	localparam logic [2:0] ST_FIN       = 3'd4;

	logic [2:0] state_q;

	logic [THR_W-1:0]  thr_q;
	logic [REFR_W-1:0] refr_q;

	logic [X_W-1:0]    column_q;
	logic [ROW_W-1:0]  prev_row_q;
	logic [TIME_W-1:0] last_beat_q;
	logic              beat_seen_q;
	logic [RATE_W-1:0] rate_value_q;
	logic              rate_valid_q;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [TIME_W-1:0]      now_q;
	logic [TIME_W-1:0]      dt_q;
	logic [PROD_W-1:0]      prod_q;
	logic [ROW_W-1:0]       row_q;
	logic                   beat_q;

	logic              out_vld_q;
	logic [X_W-1:0]    out_x_q;
	logic [ROW_W-1:0]  out_from_q;
	logic [ROW_W-1:0]  out_to_q;
	logic              out_clear_q;
	logic              out_beat_q;
	logic [RATE_W-1:0] out_rate_q;
	logic              out_known_q;

	logic [SAMPLE_BITS-1:0] in_sample;
	logic [TIME_W-1:0]      in_time;
	logic                   in_acc;
	logic                   out_free;
	logic                   wrap;
	logic                   hit;
	logic [PROD_W:0]        recip_sum;
	logic [ROW_W-1:0]       row_quot;

	div_req_t          div_req;
	div_sts_t          div_sts;
	logic [DIV_NW-1:0] div_quot;
	logic [OUT_BITS-1:0] out_word;

	assign in_sample = s_tdata[SAMPLE_BITS-1:0];
	assign in_time   = s_tdata[SAMPLE_BITS +: TIME_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;
	assign wrap      = (column_q == X_W'(PLOT_WIDTH - 1));
	assign hit       = (sample_q > thr_q) && (dt_q > TIME_W'(refr_q));

	// divide by 2^SAMPLE_BITS - 1: (p + (p >> SAMPLE_BITS) + 1) >> SAMPLE_BITS
	assign recip_sum = (PROD_W + 1)'(prod_q) + (PROD_W + 1)'(prod_q >> SAMPLE_BITS) +
		(PROD_W + 1)'(1);
	assign row_quot  = recip_sum[SAMPLE_BITS +: ROW_W];

	always_comb begin
		div_req.start    = (state_q == ST_RATE_GO);
		div_req.dividend = DIV_NW'(MS_PER_MIN);
		div_req.divisor  = dt_q;
	end

	ecgbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_W'(THR_RESET);
			refr_q <= REFR_W'(REFR_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BEAT_THRESHOLD: thr_q  <= cfg_wdata[THR_W-1:0];
				REG_REFRACTORY_MS:  refr_q <= cfg_wdata[REFR_W-1:0];
			endcase
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			column_q     <= '0;
			prev_row_q   <= ROW_W'(ROW_RESET);
			last_beat_q  <= '0;
			beat_seen_q  <= 1'b0;
			rate_value_q <= '0;
			rate_valid_q <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					state_q <= (hit && beat_seen_q) ? ST_RATE_GO : ST_FIN;
				end
				ST_RATE_GO: begin
					state_q <= ST_RATE_WAIT;
				end
				ST_RATE_WAIT: begin
					if (div_sts.done) begin
						rate_value_q <= (div_quot > DIV_NW'(RATE_MAX)) ?
							RATE_W'(RATE_MAX) : div_quot[RATE_W-1:0];
						rate_valid_q <= 1'b1;
						state_q      <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						column_q   <= wrap ? '0 : column_q + X_W'(1);
						prev_row_q <= row_q;
						if (beat_q) begin
							beat_seen_q <= 1'b1;
							last_beat_q <= now_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= in_sample;
			now_q    <= in_time;
			dt_q     <= in_time - last_beat_q;
			prod_q   <= PROD_W'(in_sample) * PROD_W'(SPAN);
		end
		if (state_q == ST_ROW) begin
			row_q  <= ROW_W'(SPAN) - row_quot;
			beat_q <= hit;
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_x_q     <= column_q;
			out_from_q  <= prev_row_q;
			out_to_q    <= row_q;
			out_clear_q <= wrap;
			out_beat_q  <= beat_q;
			out_rate_q  <= rate_value_q;
			out_known_q <= rate_valid_q;
		end
	end

	assign out_word = {out_known_q, out_rate_q, out_beat_q, out_clear_q,
		out_to_q, out_from_q, out_x_q};
	assign m_tdata  = OUT_TDATA_W'(out_word);
	assign m_tvalid = out_vld_q;

	`ECGBR_ASSERT_NXT(a_one_item, in_acc, !s_tready)
	`ECGBR_ASSERT_IMP(a_idle_div, s_tready, !div_sts.busy && !div_sts.done)
	`ECGBR_ASSERT_IMP(a_done_wait, div_sts.done, state_q == ST_RATE_WAIT)
	`ECGBR_ASSERT_NXT(a_rate_sticky, rate_valid_q, rate_valid_q)

endmodule

// ----- tb/tb_ecg_beat_rate_and_trace.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECG beat rate and trace testbench
// Streams sample/timestamp words into the block and predicts every trace
// word: plot column and rows, wrap clear, R peak flag and heart rate.
// Runs directed corner words, then randomized heartbeat-like traffic under
// several register settings, with random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_ecg_beat_rate_and_trace;
	import ecgbr_pkg::*;

	localparam int IDLE_PCT    = 36;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 150;

	typedef struct packed {
		logic              rate_known;
		logic [RATE_W-1:0] heart_rate;
		logic              beat;
		logic              clear_wave;
		logic [ROW_W-1:0]  row_to;
		logic [ROW_W-1:0]  row_from;
		logic [X_W-1:0]    seg_x;
	} trace_word_t;

	class ecg_trace_board;
		logic [THR_W-1:0]  threshold;
		logic [REFR_W-1:0] refractory;
		logic [X_W-1:0]    column;
		logic [ROW_W-1:0]  prev_row;
		logic [TIME_W-1:0] last_beat;
		bit                beat_seen;
		logic [RATE_W-1:0] rate;
		bit                rate_valid;
		trace_word_t       trace_due[$];
		int                mismatches;

		function new();
			threshold  = THR_W'(THR_RESET);
			refractory = REFR_W'(REFR_RESET);
			column     = '0;
			prev_row   = ROW_W'(ROW_RESET);
			last_beat  = '0;
			beat_seen  = 1'b0;
			rate       = '0;
			rate_valid = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_BEAT_THRESHOLD: threshold = val[THR_W-1:0];
				REG_REFRACTORY_MS:  refractory = val[REFR_W-1:0];
				default: ;
			endcase
		endfunction

		// work out the trace word caused by one accepted sample
		function void note_sample(logic [SAMPLE_BITS-1:0] smp, logic [TIME_W-1:0] t);
			trace_word_t       w;
			logic [TIME_W-1:0] gap;
			int unsigned       row;
			int unsigned       bpm;
			row = SPAN - (int'(smp) * SPAN) / SAMPLE_MAX;
			w = '0;
			w.seg_x    = column;
			w.row_from = prev_row;
			w.row_to   = row[ROW_W-1:0];
			prev_row   = row[ROW_W-1:0];
			if (int'(column) == PLOT_WIDTH - 1) begin
				column = '0;
				w.clear_wave = 1'b1;
			end else begin
				column = column + X_W'(1);
			end
			gap = t - last_beat;
			if (smp > threshold && gap > TIME_W'(refractory)) begin
				w.beat = 1'b1;
				if (beat_seen) begin
					bpm = 32'(MS_PER_MIN) / gap;
					rate = (bpm > RATE_MAX) ? RATE_W'(RATE_MAX) : bpm[RATE_W-1:0];
					rate_valid = 1'b1;
				end
				beat_seen = 1'b1;
				last_beat = t;
			end
			w.heart_rate = rate;
			w.rate_known = rate_valid;
			trace_due.push_back(w);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_word(trace_word_t got);
			trace_word_t want;
			if (trace_due.size() == 0) begin
				mismatches++;
				$display("%0t: trace word with none expected, actual %h", $time, got);
				return;
			end
			want = trace_due.pop_front();
			compare_field("seg_x", 32'(want.seg_x), 32'(got.seg_x));
			compare_field("seg_row_from", 32'(want.row_from), 32'(got.row_from));
			compare_field("seg_row_to", 32'(want.row_to), 32'(got.row_to));
			compare_field("clear_wave", 32'(want.clear_wave), 32'(got.clear_wave));
			compare_field("beat", 32'(want.beat), 32'(got.beat));
			compare_field("heart_rate", 32'(want.heart_rate), 32'(got.heart_rate));
			compare_field("rate_known", 32'(want.rate_known), 32'(got.rate_known));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	ecg_beat_rate_and_trace dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ecg_trace_board    board = new();
	bit                steady;
	bit                hold_req;
	logic [TIME_W-1:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one word, leaving tvalid high so back-to-back words need no toggle
	task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp, input logic [TIME_W-1:0] t);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
		end
		s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, t, smp};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_sample(smp, t);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (board.trace_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// drain, then write both registers on consecutive edges
	task automatic start_phase(input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] refr);
		wait_for_drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_BEAT_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		board.set_reg(REG_BEAT_THRESHOLD, thr);
		cfg_index <= REG_REFRACTORY_MS;
		cfg_wdata <= refr;
		@(posedge clk);
		board.set_reg(REG_REFRACTORY_MS, refr);
		cfg_we <= 1'b0;
	endtask

	// heartbeat-like traffic: small time steps, occasional peaks, rare jumps
	task automatic run_phase(input int count, input int hold_at, input int pause_at);
		logic [SAMPLE_BITS-1:0] smp;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) hold_req = 1'b1;
			if (i == pause_at) wait_for_drain();
			case ($urandom_range(0, 15))
				0:       clock_ms = clock_ms + $urandom_range(30000, 140000);
				1:       clock_ms = $urandom;
				default: clock_ms = clock_ms + $urandom_range(1, 400);
			endcase
			case ($urandom_range(0, 9))
				0, 1:    smp = SAMPLE_BITS'($urandom_range(600, SAMPLE_MAX));
				2:       smp = SAMPLE_BITS'($urandom);
				default: smp = SAMPLE_BITS'($urandom_range(0, 600));
			endcase
			push_sample(smp, clock_ms);
		end
	endtask

	// result side: check each accepted word, then pick tready for next cycle
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) board.check_word(trace_word_t'(m_tdata[OUT_BITS-1:0]));
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		s_tdata   = '0;
		s_tvalid  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_BEAT_THRESHOLD;
		cfg_wdata = '0;
		steady    = 1'b0;
		hold_req  = 1'b0;
		clock_ms  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: threshold edge, refractory edge, first and second beat
		push_sample('0, '0);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), '0);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), 32'd301);
		push_sample(10'd551, 32'd602);
		push_sample(10'd550, 32'd5000);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), 32'd60603);
		// zero refractory: one ms interval saturates, timestamp wrap
		start_phase(16'd0, 16'd0);
		push_sample(10'd1, 32'd60604);
		push_sample('0, 32'd60605);
		push_sample(10'd512, '1);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), '0);
		start_phase(16'(SAMPLE_MAX), 16'hFFFF);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), 32'h8000_0000);
		start_phase(16'd1022, 16'hFFFF);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), 32'h0000_FFFF);
		push_sample(SAMPLE_BITS'(SAMPLE_MAX), 32'h0001_0000);
		push_sample(10'h2AA, 32'hAAAA_AAAA);
		push_sample(10'h155, 32'h5555_5555);

		clock_ms = 32'h5555_5555;
		start_phase(16'd550, 16'd300);
		run_phase(PHASE_WORDS, 40, -1);
		start_phase(16'd0, 16'd0);
		run_phase(PHASE_WORDS, -1, 75);
		steady = 1'b1;
		start_phase(16'(SAMPLE_MAX), 16'hFFFF);
		run_phase(PHASE_WORDS, -1, -1);
		steady = 1'b0;
		start_phase(16'($urandom_range(300, 900)), 16'($urandom_range(0, 1000)));
		run_phase(PHASE_WORDS, -1, -1);
		start_phase(16'd200, 16'hFFFF);
		run_phase(PHASE_WORDS, -1, -1);
		start_phase(16'($urandom_range(0, SAMPLE_MAX)), 16'($urandom));
		run_phase(PHASE_WORDS, -1, -1);
		wait_for_drain();

		if (board.mismatches == 0 && board.trace_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- ecg_beat_rate_and_trace.f -----
+incdir+rtl
rtl/ecgbr_pkg.sv
rtl/ecgbr_div.sv
rtl/ecg_beat_rate_and_trace.sv
tb/tb_ecg_beat_rate_and_trace.sv
